// File: rtl/core/handle_table_free_list_defines.svh
`ifndef HANDLE_TABLE_FREE_LIST_DEFINES_SVH
`define HANDLE_TABLE_FREE_LIST_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HFL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HFL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/hfl_pkg.sv
package hfl_pkg;

  localparam int CAPACITY = 256;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int LINK_W   = SLOT_W + 1;
  localparam int REF_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int HOUT_W   = 8;
  localparam int OP_W     = 2;
  localparam int ST_W     = 2;
  localparam int ENTRY_W  = LINK_W + REF_W;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_MISMATCH = 2'd3
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
    logic [REF_W-1:0]    obj;
  } item_t;

  typedef struct packed {
    logic              wr_en;
    logic [LINK_W-1:0] wr_link;
    logic [REF_W-1:0]  wr_ref;
    logic [SLOT_W-1:0] head;
    logic              empty;
    logic [HOUT_W-1:0] hout;
    logic [REF_W-1:0]  rout;
    status_e           status;
  } exec_t;

endpackage

// File: rtl/core/hfl_ram.sv
module hfl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/hfl_exec.sv
module hfl_exec import hfl_pkg::*; (
  input  item_t             item_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [ENTRY_W-1:0] entry_i,
  input  logic              entry_vld_i,
  input  logic [SLOT_W-1:0] head_i,
  input  logic              empty_i,
  output exec_t             res_o
);

  logic [LINK_W-1:0] link;
  logic [REF_W-1:0]  stored_ref;
  logic              in_range;

  // unwritten slots read as their reset contents
  assign link       = entry_vld_i ? entry_i[ENTRY_W-1:REF_W]
                                  : LINK_W'({1'b0, slot_i} + LINK_W'(1));
  assign stored_ref = entry_vld_i ? entry_i[REF_W-1:0] : '0;
  assign in_range   = item_i.handle < HANDLE_W'(CAPACITY);

  always_comb begin
    res_o         = '0;
    res_o.head    = head_i;
    res_o.empty   = empty_i;
    res_o.status  = ST_OK;
    res_o.wr_link = link;
    res_o.wr_ref  = item_i.obj;
    unique case (op_e'(item_i.op))
      OP_ALLOC: begin
        if (empty_i) begin
          res_o.status = ST_FULL;
        end else begin
          res_o.wr_en = 1'b1;
          res_o.hout  = HOUT_W'(slot_i);
          if (link >= LINK_W'(CAPACITY)) begin
            res_o.empty = 1'b1;
            res_o.head  = '0;
          end else begin
            res_o.head  = link[SLOT_W-1:0];
          end
        end
      end
      OP_FREE: begin
        if (!in_range) begin
          res_o.status = ST_RANGE;
        end else if (stored_ref != item_i.obj) begin
          res_o.status = ST_MISMATCH;
        end else begin
          res_o.wr_en   = 1'b1;
          res_o.wr_link = empty_i ? LINK_W'(CAPACITY) : {1'b0, head_i};
          res_o.wr_ref  = '0;
          res_o.head    = slot_i;
          res_o.empty   = 1'b0;
        end
      end
      OP_LOOKUP: begin
        if (!in_range) begin
          res_o.status = ST_RANGE;
        end else begin
          res_o.rout = stored_ref;
        end
      end
      default: begin
        res_o.status = ST_OK;
      end
    endcase
  end

endmodule

// File: rtl/core/handle_table_free_list.sv
// Handle allocator over a fixed table of slots with an internal free list.
// Input channel (in_valid_i / in_stall_o) carries one beat per command:
// allocate (stores object_ref_i, returns the slot as handle_out_o),
// free (checks range and stored reference, then returns the slot to the list)
// or look up (returns the stored reference). Every command gives exactly one
// result beat on the output channel (out_valid_o / out_stall_i) with a status.
// Timing: a command accepted at an edge reads the slot memory at that edge and
// its result is registered in the output register once that register is free.
// in_stall_o stays high through the slot memory read-modify-write of a command.
// A result waiting under out_stall_i does not block accepting the next
// command; that command completes once the output register is taken.
// Reset: all slots are free, linked in ascending order starting at slot 0,
// with cleared references; per-slot valid flags make this take effect at
// once, with no clearing pass. Commands may be sent right after reset.
`include "handle_table_free_list_defines.svh"

module handle_table_free_list import hfl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [REF_W-1:0]    object_ref_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [HOUT_W-1:0]   handle_out_o,
  output logic [REF_W-1:0]    ref_out_o,
  output logic [ST_W-1:0]     status_o
);

  logic                busy_q;
  logic [SLOT_W-1:0]   head_q;
  logic                empty_q;
  logic [CAPACITY-1:0] slot_vld_q;
  item_t               item_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                rd_vld_q;
  logic                out_valid_q;
  logic [HOUT_W-1:0]   hout_q;
  logic [REF_W-1:0]    rout_q;
  logic [ST_W-1:0]     status_q;

  logic                accept;
  logic                done;
  logic [SLOT_W-1:0]   rd_slot;
  logic [ENTRY_W-1:0]  entry;
  logic                wr_en;
  exec_t               res;

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign done       = busy_q && (!out_valid_q || !out_stall_i);
  assign rd_slot    = (op_e'(operation_i) == OP_ALLOC) ? head_q : handle_i[SLOT_W-1:0];
  assign wr_en      = done && res.wr_en;

  hfl_ram #(
    .Width (ENTRY_W),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (slot_q),
    .wdata_i ({res.wr_link, res.wr_ref}),
    .re_i    (accept),
    .raddr_i (rd_slot),
    .rdata_o (entry)
  );

  hfl_exec u_exec (
    .item_i      (item_q),
    .slot_i      (slot_q),
    .entry_i     (entry),
    .entry_vld_i (rd_vld_q),
    .head_i      (head_q),
    .empty_i     (empty_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      head_q      <= '0;
      empty_q     <= 1'b0;
      slot_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        head_q      <= res.head;
        empty_q     <= res.empty;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en) begin
        slot_vld_q[slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q   <= '{op: operation_i, handle: handle_i, obj: object_ref_i};
      slot_q   <= rd_slot;
      rd_vld_q <= slot_vld_q[rd_slot];
    end
    if (done) begin
      hout_q   <= res.hout;
      rout_q   <= res.rout;
      status_q <= res.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign handle_out_o = hout_q;
  assign ref_out_o    = rout_q;
  assign status_o     = status_q;

  `HFL_ASSERT_IMP(a_no_accept_busy, busy_q, in_stall_o, "beat accepted while busy")
  `HFL_ASSERT_IMP(a_empty_head, empty_q, head_q == '0, "empty list with nonzero head")
  `HFL_ASSERT_NXT(a_done_out, done, out_valid_o, "completed command gave no result")
  `HFL_ASSERT_IMP(a_wr_done, wr_en, busy_q && done, "slot write outside completion")

endmodule
